@@ rtl/core/lfpc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the control-store program of the line follower core.
// No dependencies; every other file imports this package.
package lfpc_pkg;

  localparam int unsigned SENSOR_COUNT_DEF = 8;
  localparam int unsigned SAMPLE_W         = 8;
  localparam int unsigned JUNCTION_COUNT   = 6;
  localparam int unsigned ERR_W            = 11;
  localparam int unsigned ERR_LIMIT        = 1023;
  localparam int unsigned INTEG_W          = 24;
  localparam int unsigned GAIN_W           = 16;
  localparam int unsigned SPEED_W          = 8;
  localparam int unsigned FRAC_W           = 16;
  localparam int unsigned ACC_W            = 42;
  localparam int unsigned CORR_W           = ACC_W - FRAC_W;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 16;
  localparam int unsigned UPC_W            = 4;
  localparam int unsigned TDATA_W          = 32;
  localparam int unsigned TUSER_W          = 2;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd3840;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd1280;
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 8'd130;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RST   = 8'd100;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = 8'd180;
  localparam logic [SPEED_W-1:0] PIVOT_SPEED_RST = 8'd130;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_BASE_SPEED  = 3'd3,
    REG_MIN_SPEED   = 3'd4,
    REG_MAX_SPEED   = 3'd5,
    REG_PIVOT_SPEED = 3'd6,
    REG_ACTIVE_HIGH = 3'd7
  } cfg_reg_e;

  typedef enum logic [TUSER_W-1:0] {
    ST_FOLLOW   = 2'd0,
    ST_SEARCH   = 2'd1,
    ST_JUNCTION = 2'd2,
    ST_HALTED   = 2'd3
  } drive_status_e;

  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_CLASSIFY,
    UOP_DIV,
    UOP_ERR,
    UOP_MAC_P,
    UOP_MAC_I,
    UOP_MAC_D,
    UOP_CORR,
    UOP_OUT_FOLLOW,
    UOP_OUT_HALT,
    UOP_OUT_PIVOT,
    UOP_OUT_JUNCTION
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_HALTED,
    COND_NO_LINE,
    COND_JUNCTION,
    COND_DIV_MORE
  } cond_e;

  typedef struct packed {
    uop_e             op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic             last;
  } ucode_t;

  typedef struct packed {
    uop_e op;
    logic en;
  } ctl_t;

  typedef struct packed {
    logic halted;
    logic no_line;
    logic junction;
    logic div_more;
  } stat_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] max_speed;
    logic [SPEED_W-1:0] pivot_speed;
    logic               active_high;
  } cfg_t;

  typedef struct packed {
    logic                    left_forward;
    logic [SPEED_W-1:0]      left_duty;
    logic                    right_forward;
    logic [SPEED_W-1:0]      right_duty;
    drive_status_e           status;
    logic signed [ERR_W-1:0] line_error;
  } result_t;

  localparam logic [UPC_W-1:0] UA_CLASSIFY   = 4'd0;
  localparam logic [UPC_W-1:0] UA_HALT_TEST  = 4'd1;
  localparam logic [UPC_W-1:0] UA_LINE_TEST  = 4'd2;
  localparam logic [UPC_W-1:0] UA_JUNC_TEST  = 4'd3;
  localparam logic [UPC_W-1:0] UA_DIV        = 4'd4;
  localparam logic [UPC_W-1:0] UA_ERR        = 4'd5;
  localparam logic [UPC_W-1:0] UA_MAC_P      = 4'd6;
  localparam logic [UPC_W-1:0] UA_MAC_I      = 4'd7;
  localparam logic [UPC_W-1:0] UA_MAC_D      = 4'd8;
  localparam logic [UPC_W-1:0] UA_CORR       = 4'd9;
  localparam logic [UPC_W-1:0] UA_OUT_FOLLOW = 4'd10;
  localparam logic [UPC_W-1:0] UA_OUT_HALT   = 4'd11;
  localparam logic [UPC_W-1:0] UA_OUT_PIVOT  = 4'd12;
  localparam logic [UPC_W-1:0] UA_OUT_JUNC   = 4'd13;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      UA_CLASSIFY:   w = '{UOP_CLASSIFY,     COND_NEVER,    UA_CLASSIFY,  1'b0};
      UA_HALT_TEST:  w = '{UOP_NONE,         COND_HALTED,   UA_OUT_HALT,  1'b0};
      UA_LINE_TEST:  w = '{UOP_NONE,         COND_NO_LINE,  UA_OUT_PIVOT, 1'b0};
      UA_JUNC_TEST:  w = '{UOP_NONE,         COND_JUNCTION, UA_OUT_JUNC,  1'b0};
      UA_DIV:        w = '{UOP_DIV,          COND_DIV_MORE, UA_DIV,       1'b0};
      UA_ERR:        w = '{UOP_ERR,          COND_NEVER,    UA_CLASSIFY,  1'b0};
      UA_MAC_P:      w = '{UOP_MAC_P,        COND_NEVER,    UA_CLASSIFY,  1'b0};
      UA_MAC_I:      w = '{UOP_MAC_I,        COND_NEVER,    UA_CLASSIFY,  1'b0};
      UA_MAC_D:      w = '{UOP_MAC_D,        COND_NEVER,    UA_CLASSIFY,  1'b0};
      UA_CORR:       w = '{UOP_CORR,         COND_NEVER,    UA_CLASSIFY,  1'b0};
      UA_OUT_FOLLOW: w = '{UOP_OUT_FOLLOW,   COND_NEVER,    UA_CLASSIFY,  1'b1};
      UA_OUT_HALT:   w = '{UOP_OUT_HALT,     COND_NEVER,    UA_CLASSIFY,  1'b1};
      UA_OUT_PIVOT:  w = '{UOP_OUT_PIVOT,    COND_NEVER,    UA_CLASSIFY,  1'b1};
      UA_OUT_JUNC:   w = '{UOP_OUT_JUNCTION, COND_NEVER,    UA_CLASSIFY,  1'b1};
      default:       w = '{UOP_NONE,         COND_NEVER,    UA_CLASSIFY,  1'b1};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/line_follower_pid_controller_core.sv @@
`timescale 1ns / 1ps
// Line follower steering core: one sensor word in, one motor command word out.
// Depends on lfpc_pkg, lfpc_useq, lfpc_datapath.
//
// Each sensor word runs through a short microprogram, one step per cycle except that the last
// step waits while the output register holds an untaken word. The core takes no new word
// until it has handed its result to the output register. The divider retires two quotient
// bits per cycle over the magnitude of the weighted sensor sum. A lost line, a junction and
// every word after a junction skip the divider and the PID steps. Configuration writes are
// always accepted and take effect on the next word only if made while the core is idle; the
// core itself does not enforce this.
module line_follower_pid_controller_core #(
  parameter int unsigned SENSOR_COUNT = lfpc_pkg::SENSOR_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lfpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lfpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] sensor_bits
  input  logic [lfpc_pkg::SAMPLE_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] left_forward, [8:1] left_duty, [9] right_forward, [17:10] right_duty,
  // [28:18] line_error, [31:29] zero
  output logic [lfpc_pkg::TDATA_W-1:0]    m_axis_tdata_o,
  // [1:0] drive_status
  output logic [lfpc_pkg::TUSER_W-1:0]    m_axis_tuser_o
);
  import lfpc_pkg::*;

  cfg_t    cfg_q;
  ctl_t    ctl;
  stat_t   stat;
  result_t res;
  result_t res_q;
  logic    m_valid_q;
  logic    start;
  logic    emit;
  logic    busy;
  logic    out_free;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = ~busy;
  assign start           = s_axis_tvalid_i & ~busy;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, BASE_SPEED_RST,
                 MIN_SPEED_RST, MAX_SPEED_RST, PIVOT_SPEED_RST, 1'b0};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GAIN_P:      cfg_q.gain_p      <= cfg_data_i;
        REG_GAIN_I:      cfg_q.gain_i      <= cfg_data_i;
        REG_GAIN_D:      cfg_q.gain_d      <= cfg_data_i;
        REG_BASE_SPEED:  cfg_q.base_speed  <= cfg_data_i[SPEED_W-1:0];
        REG_MIN_SPEED:   cfg_q.min_speed   <= cfg_data_i[SPEED_W-1:0];
        REG_MAX_SPEED:   cfg_q.max_speed   <= cfg_data_i[SPEED_W-1:0];
        REG_PIVOT_SPEED: cfg_q.pivot_speed <= cfg_data_i[SPEED_W-1:0];
        REG_ACTIVE_HIGH: cfg_q.active_high <= cfg_data_i[0];
      endcase
    end
  end

  lfpc_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .emit_o     (emit),
    .busy_o     (busy)
  );

  lfpc_datapath #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (start),
    .sample_i (s_axis_tdata_i),
    .cfg_i    (cfg_q),
    .ctl_i    (ctl),
    .stat_o   (stat),
    .result_o (res)
  );

  // hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_q.line_error, res_q.right_duty, res_q.right_forward,
                            res_q.left_duty, res_q.left_forward};
  assign m_axis_tuser_o  = res_q.status;

endmodule

@@ rtl/core/lfpc_useq.sv @@
`timescale 1ns / 1ps
// Microsequencer: step counter over the control store, conditional jumps, end-of-program handoff.
// Depends on lfpc_pkg.
module lfpc_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            out_free_i,
  input  lfpc_pkg::stat_t stat_i,
  output lfpc_pkg::ctl_t  ctl_o,
  output logic            emit_o,
  output logic            busy_o
);
  import lfpc_pkg::*;

  ucode_t           word;
  logic             cond_hit;
  logic             hold;
  logic [UPC_W-1:0] upc_d, upc_q;
  logic             busy_d, busy_q;

  always_comb begin
    word = ucode_rom(upc_q);
    unique case (word.cond)
      COND_HALTED:   cond_hit = stat_i.halted;
      COND_NO_LINE:  cond_hit = stat_i.no_line;
      COND_JUNCTION: cond_hit = stat_i.junction;
      COND_DIV_MORE: cond_hit = stat_i.div_more;
      default:       cond_hit = 1'b0;
    endcase
  end

  assign hold      = word.last & ~out_free_i;
  assign ctl_o.op  = word.op;
  assign ctl_o.en  = busy_q & ~hold;
  assign emit_o    = busy_q & word.last & out_free_i;
  assign busy_o    = busy_q;

  always_comb begin
    upc_d  = upc_q;
    busy_d = busy_q;
    priority if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        upc_d  = UA_CLASSIFY;
      end
    end else if (word.last) begin
      if (out_free_i) begin
        busy_d = 1'b0;
      end
    end else if (cond_hit) begin
      upc_d = word.target;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= UA_CLASSIFY;
      busy_q <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      busy_q <= busy_d;
    end
  end

endmodule

@@ rtl/core/lfpc_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: sensor decode, radix-4 divider, shared multiplier-accumulator, clamp and result build.
// Depends on lfpc_pkg; driven one micro-op per cycle by lfpc_useq unless the output stalls it.
module lfpc_datapath #(
  parameter int unsigned SENSOR_COUNT = lfpc_pkg::SENSOR_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [lfpc_pkg::SAMPLE_W-1:0]  sample_i,
  input  lfpc_pkg::cfg_t                 cfg_i,
  input  lfpc_pkg::ctl_t                 ctl_i,
  output lfpc_pkg::stat_t                stat_o,
  output lfpc_pkg::result_t              result_o
);
  import lfpc_pkg::*;

  localparam int unsigned ACT_W     = $clog2(SENSOR_COUNT + 1);
  localparam int unsigned SUM_W     = $clog2(SENSOR_COUNT * SENSOR_COUNT * 128 + 1) + 1;
  localparam int unsigned MAG_W     = SUM_W - 1;
  localparam int unsigned DIV_STEPS = (MAG_W + 1) / 2;
  localparam int unsigned DQ_W      = 2 * DIV_STEPS;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned QX_W      = (DQ_W > ERR_W) ? DQ_W : ERR_W;
  localparam int unsigned USED_W    = (SENSOR_COUNT < SAMPLE_W) ? SENSOR_COUNT : SAMPLE_W;
  localparam int unsigned PROD_W    = GAIN_W + 1 + INTEG_W;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << FRAC_W) - 64'd1);
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  function automatic logic signed [SUM_W-1:0] weight(input int k);
    return SUM_W'((2 * k - (int'(SENSOR_COUNT) - 1)) * 128);
  endfunction

  function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [CORR_W:0] x,
                                                     input logic signed [CORR_W:0] lo,
                                                     input logic signed [CORR_W:0] hi);
    logic signed [CORR_W:0] y;
    priority if (x < lo) y = lo;
    else if (x > hi)     y = hi;
    else                 y = x;
    return y[SPEED_W-1:0];
  endfunction

  // payload
  logic [SAMPLE_W-1:0]       sample_q;
  logic [ACT_W-1:0]          act_q;
  logic                      neg_q;
  logic [ACT_W-1:0]          rem_q;
  logic [DQ_W-1:0]           dq_q;
  logic [CNT_W-1:0]          cnt_q;
  logic signed [ERR_W-1:0]   e_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [SPEED_W-1:0]        left_q, right_q;
  // architectural state
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   prev_q, last_q;
  logic                      halted_q;

  logic [SENSOR_COUNT-1:0]   raw, rev, bits;
  logic [ACT_W-1:0]          act_cnt;
  logic signed [SUM_W-1:0]   wsum, wabs;
  logic [ACT_W-1:0]          rem_d;
  logic [DQ_W-1:0]           dq_d;
  logic [ACT_W:0]            trial;
  logic [QX_W-1:0]           q_x;
  logic signed [ERR_W-1:0]   e_abs, e_new;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] integ_new;
  logic signed [ERR_W:0]     diff;
  logic signed [GAIN_W:0]    mul_a;
  logic signed [INTEG_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]          acc_b;
  logic signed [CORR_W-1:0]  corr;
  logic signed [CORR_W:0]    base_x, min_x, max_x, lsum, rsum;
  logic                      right_turn;
  logic                      pivot_zero;

  // decode sample
  always_comb begin
    raw = '0;
    raw[USED_W-1:0] = sample_q[USED_W-1:0];
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      rev[SENSOR_COUNT-1-k] = raw[k];
    end
    bits    = cfg_i.active_high ? rev : ~rev;
    act_cnt = '0;
    wsum    = '0;
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      if (bits[k]) begin
        act_cnt = act_cnt + ACT_W'(1);
        wsum    = wsum + weight(k);
      end
    end
    wabs = wsum[SUM_W-1] ? -wsum : wsum;
  end

  // two restoring steps per cycle
  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_d, dq_d[DQ_W-1]};
      dq_d  = {dq_d[DQ_W-2:0], 1'b0};
      if (trial >= {1'b0, act_q}) begin
        rem_d   = ACT_W'(trial - {1'b0, act_q});
        dq_d[0] = 1'b1;
      end else begin
        rem_d = trial[ACT_W-1:0];
      end
    end
  end

  // error and integral
  always_comb begin
    q_x   = QX_W'(dq_q);
    e_abs = (q_x > QX_W'(ERR_LIMIT)) ? ERR_W'(ERR_LIMIT) : q_x[ERR_W-1:0];
    e_new = neg_q ? -e_abs : e_abs;
    isum  = $signed({integ_q[INTEG_W-1], integ_q}) + (INTEG_W+1)'(e_new);
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      integ_new = isum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_new = isum[INTEG_W-1:0];
    end
  end

  // shared multiplier
  always_comb begin
    diff = $signed({e_q[ERR_W-1], e_q}) - $signed({prev_q[ERR_W-1], prev_q});
    unique case (ctl_i.op)
      UOP_MAC_I: begin
        mul_a = $signed({1'b0, cfg_i.gain_i});
        mul_b = integ_q;
      end
      UOP_MAC_D: begin
        mul_a = $signed({1'b0, cfg_i.gain_d});
        mul_b = INTEG_W'(diff);
      end
      default: begin
        mul_a = $signed({1'b0, cfg_i.gain_p});
        mul_b = INTEG_W'(e_q);
      end
    endcase
    prod = mul_a * mul_b;
  end

  // correction and clamp
  always_comb begin
    acc_b  = acc_q + (acc_q[ACC_W-1] ? ROUND_BIAS : '0);
    corr   = acc_b[ACC_W-1:FRAC_W];
    base_x = $signed({{(CORR_W+1-SPEED_W){1'b0}}, cfg_i.base_speed});
    min_x  = $signed({{(CORR_W+1-SPEED_W){1'b0}}, cfg_i.min_speed});
    max_x  = $signed({{(CORR_W+1-SPEED_W){1'b0}}, cfg_i.max_speed});
    lsum   = base_x + (CORR_W+1)'(corr);
    rsum   = base_x - (CORR_W+1)'(corr);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= sample_i;
    end
    if (ctl_i.en) begin
      unique case (ctl_i.op)
        UOP_CLASSIFY: begin
          act_q <= act_cnt;
          neg_q <= wsum[SUM_W-1];
          dq_q  <= DQ_W'(wabs[MAG_W-1:0]);
          rem_q <= '0;
          cnt_q <= '0;
        end
        UOP_DIV: begin
          dq_q  <= dq_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q + CNT_W'(1);
        end
        UOP_ERR:   e_q   <= e_new;
        UOP_MAC_P: acc_q <= ACC_W'(prod);
        UOP_MAC_I: acc_q <= acc_q + ACC_W'(prod);
        UOP_MAC_D: acc_q <= acc_q + ACC_W'(prod);
        UOP_CORR: begin
          left_q  <= clamp_speed(lsum, min_x, max_x);
          right_q <= clamp_speed(rsum, min_x, max_x);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q  <= '0;
      prev_q   <= '0;
      last_q   <= '0;
      halted_q <= 1'b0;
    end else if (ctl_i.en) begin
      unique case (ctl_i.op)
        UOP_ERR: integ_q <= integ_new;
        UOP_CORR: begin
          prev_q <= e_q;
          last_q <= e_q;
        end
        UOP_OUT_PIVOT: begin
          integ_q <= '0;
          prev_q  <= '0;
        end
        UOP_OUT_JUNCTION: halted_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign stat_o.halted   = halted_q;
  assign stat_o.no_line  = (act_q == '0);
  assign stat_o.junction = (32'(act_q) >= JUNCTION_COUNT);
  assign stat_o.div_more = (cnt_q != CNT_W'(DIV_STEPS - 1));

  assign right_turn = (last_q > $signed(ERR_W'(0)));
  assign pivot_zero = (cfg_i.pivot_speed == '0);

  always_comb begin
    unique case (ctl_i.op)
      UOP_OUT_HALT: begin
        result_o = '{1'b1, '0, 1'b1, '0, ST_HALTED, '0};
      end
      UOP_OUT_JUNCTION: begin
        result_o = '{1'b1, '0, 1'b1, '0, ST_JUNCTION, '0};
      end
      UOP_OUT_PIVOT: begin
        result_o = '{right_turn ? 1'b1 : pivot_zero, cfg_i.pivot_speed,
                     right_turn ? pivot_zero : 1'b1, cfg_i.pivot_speed,
                     ST_SEARCH, '0};
      end
      default: begin
        result_o = '{1'b1, left_q, 1'b1, right_q, ST_FOLLOW, e_q};
      end
    endcase
  end

endmodule

@@ rtl/core/lfpc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the line follower core, bound to the top level.
// Depends on lfpc_pkg and line_follower_pid_controller_core.
module lfpc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [lfpc_pkg::TDATA_W-1:0]    m_axis_tdata_o,
  input logic [lfpc_pkg::TUSER_W-1:0]    m_axis_tuser_o
);
  import lfpc_pkg::*;

  localparam logic [TDATA_W-1:0] STOP_WORD = 32'h0000_0201;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("new sensor word taken while one is in progress");

  a_stop_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_HALTED || m_axis_tuser_o == ST_JUNCTION)
    |-> m_axis_tdata_o == STOP_WORD)
    else $error("stopped robot not commanded to zero duty");

  a_search_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_SEARCH
    |-> m_axis_tdata_o[28:18] == '0 && m_axis_tdata_o[8:1] == m_axis_tdata_o[17:10])
    else $error("pivot word carries error or unequal duties");

  a_follow_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_FOLLOW
    |-> m_axis_tdata_o[0] && m_axis_tdata_o[9] && m_axis_tdata_o[31:29] == '0)
    else $error("following word not driving both wheels forward");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i
    |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result word changed");

endmodule

bind line_follower_pid_controller_core lfpc_checker u_lfpc_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for line_follower_pid_controller_core: sensor words in, motor command words
// out, each checked against a typed row or an in-bench predictor. Depends on lfpc_pkg and the core.
module testbench;
  import lfpc_pkg::*;

  localparam int OPEN_ROWS        = 20;
  localparam int PROBE_ROWS       = 24;
  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int SAT_RUN          = 60;
  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int REPORT_LIMIT     = 20;
  localparam longint INTEG_TOP    = (longint'(1) << (INTEG_W - 1)) - 1;
  localparam longint INTEG_BOTTOM = -(longint'(1) << (INTEG_W - 1));

  typedef struct packed {
    logic [7:0] sample;
    logic       typed;
    result_t    cmd;
  } probe_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [SAMPLE_W-1:0]   s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [TDATA_W-1:0]    m_axis_tdata_o;
  logic [TUSER_W-1:0]    m_axis_tuser_o;

  cfg_t                  knobs;
  logic signed [23:0]    integ_acc;
  logic signed [10:0]    prev_err;
  logic signed [10:0]    last_err;
  logic                  halted_seen;
  result_t               pending_cmds[$];
  bit                    calm;
  int                    mismatches;
  int                    words_sent;
  int                    words_checked;
  int                    settings_used;
  int                    status_seen[4];
  int                    cycles;

  // Opening rows run at reset settings (sensors active low); the last four close the run.
  probe_row_t probes [PROBE_ROWS] = '{
    '{8'hFF, 1'b1, '{1'b0, 8'd130, 1'b1, 8'd130, ST_SEARCH, 11'sd0}},
    '{8'hFE, 1'b1, '{1'b1, 8'd180, 1'b1, 8'd100, ST_FOLLOW, 11'sd896}},
    '{8'hFF, 1'b1, '{1'b1, 8'd130, 1'b0, 8'd130, ST_SEARCH, 11'sd0}},
    '{8'h7F, 1'b1, '{1'b1, 8'd100, 1'b1, 8'd180, ST_FOLLOW, -11'sd896}},
    '{8'hE7, 1'b0, '0},
    '{8'hEF, 1'b0, '0},
    '{8'hF7, 1'b0, '0},
    '{8'hFD, 1'b0, '0},
    '{8'hBF, 1'b0, '0},
    '{8'hF9, 1'b0, '0},
    '{8'h9F, 1'b0, '0},
    '{8'hE3, 1'b0, '0},
    '{8'hC7, 1'b0, '0},
    '{8'h07, 1'b0, '0},
    '{8'hE0, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFB, 1'b0, '0},
    '{8'h03, 1'b1, '{1'b1, 8'd0, 1'b1, 8'd0, ST_JUNCTION, 11'sd0}},
    '{8'h00, 1'b1, '{1'b1, 8'd0, 1'b1, 8'd0, ST_HALTED, 11'sd0}},
    '{8'hFF, 1'b1, '{1'b1, 8'd0, 1'b1, 8'd0, ST_HALTED, 11'sd0}},
    '{8'hFE, 1'b1, '{1'b1, 8'd0, 1'b1, 8'd0, ST_HALTED, 11'sd0}}
  };

  line_follower_pid_controller_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 30);
  endfunction

  function automatic logic [7:0] clamp_duty(input longint speed);
    if (speed < longint'(knobs.min_speed)) return knobs.min_speed;
    if (speed > longint'(knobs.max_speed)) return knobs.max_speed;
    return speed[7:0];
  endfunction

  function automatic result_t predict_steering(input logic [7:0] raw);
    result_t    cmd;
    logic [7:0] seen;
    logic [7:0] pivot;
    int         hits;
    int         wsum;
    int         err;
    longint     sum;
    longint     acc;
    longint     corr;
    cmd = '{1'b1, 8'd0, 1'b1, 8'd0, ST_HALTED, 11'sd0};
    if (halted_seen) return cmd;
    hits = 0;
    wsum = 0;
    for (int k = 0; k < 8; k++) seen[7-k] = raw[k];
    if (!knobs.active_high) seen = ~seen;
    for (int k = 0; k < 8; k++) begin
      if (seen[k]) begin
        wsum += (2 * k - 7) * 128;
        hits++;
      end
    end
    if (hits == 0) begin
      pivot = knobs.pivot_speed;
      cmd.status = ST_SEARCH;
      cmd.left_duty = pivot;
      cmd.right_duty = pivot;
      if (last_err > 0) begin
        cmd.left_forward = 1'b1;
        cmd.right_forward = (pivot == 8'd0);
      end else begin
        cmd.left_forward = (pivot == 8'd0);
        cmd.right_forward = 1'b1;
      end
      integ_acc = '0;
      prev_err = '0;
      return cmd;
    end
    if (hits >= int'(JUNCTION_COUNT)) begin
      halted_seen = 1'b1;
      cmd.status = ST_JUNCTION;
      return cmd;
    end
    err = wsum / hits;
    sum = longint'(integ_acc) + err;
    if (sum > INTEG_TOP) sum = INTEG_TOP;
    if (sum < INTEG_BOTTOM) sum = INTEG_BOTTOM;
    integ_acc = sum[23:0];
    acc = longint'(knobs.gain_p) * err + longint'(knobs.gain_i) * sum
        + longint'(knobs.gain_d) * (err - longint'(prev_err));
    corr = acc / 65536;
    prev_err = err[10:0];
    last_err = err[10:0];
    cmd.left_duty = clamp_duty(longint'(knobs.base_speed) + corr);
    cmd.right_duty = clamp_duty(longint'(knobs.base_speed) - corr);
    cmd.status = ST_FOLLOW;
    cmd.line_error = err[10:0];
    return cmd;
  endfunction

  // Draw a sample: mostly a narrow line under the array, some lost line, some clutter.
  function automatic logic [7:0] draw_sample();
    logic [7:0] seen;
    logic [7:0] raw;
    int         kind;
    int         span;
    kind = $urandom_range(99);
    if (kind < 70) begin
      span = $urandom_range(1, 3);
      seen = ((8'd1 << span) - 8'd1) << $urandom_range(0, 8 - span);
    end else if (kind < 80) begin
      seen = 8'd0;
    end else begin
      do seen = 8'($urandom_range(255)); while ($countones(seen) > 5);
    end
    for (int k = 0; k < 8; k++) raw[k] = seen[7-k];
    return knobs.active_high ? raw : ~raw;
  endfunction

  function automatic cfg_t pick_setting(input int phase);
    cfg_t s;
    logic [7:0] swap;
    case (phase)
      0: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 8'd255, 8'd255, 1'b1};
      1: s = '{16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
      2: s = '{16'd3840, 16'd64, 16'd1280, 8'd128, 8'd200, 8'd50, 8'd1, 1'b1};
      default: begin
        s.gain_p = $urandom_range(1) ? 16'($urandom_range(2047)) : 16'($urandom);
        s.gain_i = $urandom_range(1) ? 16'($urandom_range(255)) : 16'($urandom);
        s.gain_d = $urandom_range(1) ? 16'($urandom_range(2047)) : 16'($urandom);
        s.base_speed = 8'($urandom_range(255));
        s.min_speed = 8'($urandom_range(0, 120));
        s.max_speed = 8'($urandom_range(130, 255));
        if ($urandom_range(3) == 0) begin
          swap = s.min_speed;
          s.min_speed = s.max_speed;
          s.max_speed = swap;
        end
        s.pivot_speed = 8'($urandom_range(255));
        s.active_high = 1'($urandom_range(1));
      end
    endcase
    return s;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_GAIN_P:      knobs.gain_p = val;
      REG_GAIN_I:      knobs.gain_i = val;
      REG_GAIN_D:      knobs.gain_d = val;
      REG_BASE_SPEED:  knobs.base_speed = val[7:0];
      REG_MIN_SPEED:   knobs.min_speed = val[7:0];
      REG_MAX_SPEED:   knobs.max_speed = val[7:0];
      REG_PIVOT_SPEED: knobs.pivot_speed = val[7:0];
      REG_ACTIVE_HIGH: knobs.active_high = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Upper bits of narrow registers carry junk that the block must drop.
  task automatic apply_setting(input cfg_t s);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_GAIN_P, s.gain_p);
    write_reg(REG_GAIN_I, s.gain_i);
    write_reg(REG_GAIN_D, s.gain_d);
    write_reg(REG_BASE_SPEED, {junk[15:8], s.base_speed});
    write_reg(REG_MIN_SPEED, {junk[7:0], s.min_speed});
    write_reg(REG_MAX_SPEED, {junk[11:4], s.max_speed});
    write_reg(REG_PIVOT_SPEED, {junk[14:7], s.pivot_speed});
    write_reg(REG_ACTIVE_HIGH, {junk[15:1], s.active_high});
    settings_used++;
  endtask

  task automatic push_sample(input logic [7:0] sample, input logic typed, input result_t cmd);
    result_t want;
    @(negedge clk_i);
    while (take_break()) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sample;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    want = predict_steering(sample);
    pending_cmds.push_back(typed ? cmd : want);
    words_sent++;
  endtask

  task automatic drain_words();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: random stalls unless calm; check each accepted word against the oldest expectation.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= rst_ni && !take_break();
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{m_axis_tdata_o[0], m_axis_tdata_o[8:1], m_axis_tdata_o[9],
              m_axis_tdata_o[17:10], drive_status_e'(m_axis_tuser_o),
              m_axis_tdata_o[28:18]};
      if (pending_cmds.size() == 0) begin
        log_mismatch($sformatf("unexpected word tdata=%h tuser=%h",
                               m_axis_tdata_o, m_axis_tuser_o));
      end else begin
        want = pending_cmds.pop_front();
        words_checked++;
        status_seen[want.status]++;
        if (got.left_forward !== want.left_forward)
          log_mismatch($sformatf("left_forward %b, want %b", got.left_forward,
                                 want.left_forward));
        if (got.left_duty !== want.left_duty)
          log_mismatch($sformatf("left_duty %0d, want %0d", got.left_duty, want.left_duty));
        if (got.right_forward !== want.right_forward)
          log_mismatch($sformatf("right_forward %b, want %b", got.right_forward,
                                 want.right_forward));
        if (got.right_duty !== want.right_duty)
          log_mismatch($sformatf("right_duty %0d, want %0d", got.right_duty,
                                 want.right_duty));
        if (got.status !== want.status)
          log_mismatch($sformatf("drive_status %0d, want %0d", got.status, want.status));
        if (got.line_error !== want.line_error)
          log_mismatch($sformatf("line_error %0d, want %0d", got.line_error,
                                 want.line_error));
        if (m_axis_tdata_o[31:29] !== 3'b000)
          log_mismatch($sformatf("tdata pad bits %b", m_axis_tdata_o[31:29]));
      end
    end
  end

  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("run exceeded %0d cycles, %0d words still expected", CYCLE_LIMIT,
             pending_cmds.size());
    $display("** line_follower_pid_controller_core: FAILED **");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_GAIN_P;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    calm            = 1'b0;
    knobs = '{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, BASE_SPEED_RST, MIN_SPEED_RST,
              MAX_SPEED_RST, PIVOT_SPEED_RST, 1'b0};
    integ_acc   = '0;
    prev_err    = '0;
    last_err    = '0;
    halted_seen = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < OPEN_ROWS; i++)
      push_sample(probes[i].sample, probes[i].typed, probes[i].cmd);
    drain_words();

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(pick_setting(ph));
      calm = (ph == 4);
      repeat (RANDOM_PER_PHASE) push_sample(draw_sample(), 1'b0, '0);
      drain_words();
    end

    // Ramp the integral one way, then the other: integral gain only, line pinned to one edge.
    apply_setting('{16'd0, 16'd64, 16'd0, 8'd128, 8'd0, 8'd255, 8'd50, 1'b1});
    calm = 1'b1;
    push_sample(8'h00, 1'b0, '0);
    repeat (SAT_RUN) push_sample(8'h01, 1'b0, '0);
    push_sample(8'h00, 1'b0, '0);
    repeat (SAT_RUN) push_sample(8'h80, 1'b0, '0);
    calm = 1'b0;
    drain_words();

    write_reg(REG_ACTIVE_HIGH, 16'h0000);
    for (int i = OPEN_ROWS; i < PROBE_ROWS; i++)
      push_sample(probes[i].sample, probes[i].typed, probes[i].cmd);
    drain_words();
    repeat (30) @(posedge clk_i);

    $display("checked %0d of %0d sensor words across %0d register settings",
             words_checked, words_sent, settings_used);
    $display("following %0d, searching %0d, junction %0d, halted %0d; %0d mismatches",
             status_seen[ST_FOLLOW], status_seen[ST_SEARCH], status_seen[ST_JUNCTION],
             status_seen[ST_HALTED], mismatches);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("** line_follower_pid_controller_core: PASSED **");
    end else begin
      $display("** line_follower_pid_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ line_follower_pid_controller_core.f @@
rtl/core/lfpc_pkg.sv
rtl/core/lfpc_useq.sv
rtl/core/lfpc_datapath.sv
rtl/core/line_follower_pid_controller_core.sv
rtl/core/lfpc_checker.sv
tb/testbench.sv
